/* rtl/core/hrhp_pkg.sv */
// Shared types and constants for the HTTP request header parser.
`default_nettype none
package hrhp_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_new;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               uri_byte;
    logic [1:0]         method_code;
    logic               version_minor;
    logic               persist;
    logic               has_host;
    logic               has_length;
    logic signed [31:0] body_len;
  } out_item_t;

  typedef enum logic [1:0] {
    PH_LINE = 2'd0,
    PH_HEAD = 2'd1,
    PH_DONE = 2'd2,
    PH_ERR  = 2'd3
  } phase_t;

  typedef enum logic [4:0] {
    S_M0, S_METHOD, S_SP_URI, S_URI, S_SP_VER, S_H, S_HT, S_HTT, S_HTTP, S_SL,
    S_ONE, S_DOT, S_SP_END, S_LCR, S_H0, S_NAME, S_SP_VAL, S_VAL, S_HCR, S_ECR
  } pstate_t;

  typedef enum logic [1:0] {
    K_NONE = 2'd0,
    K_HOST = 2'd1,
    K_CONN = 2'd2,
    K_CLEN = 2'd3
  } hkind_t;

  typedef enum logic [2:0] {
    N_START, N_SIGN, N_ZERO, N_X, N_DIG, N_STOP
  } nstage_t;

  typedef enum logic [1:0] {
    B_DEC = 2'd0,
    B_OCT = 2'd1,
    B_HEX = 2'd2
  } nbase_t;

  localparam logic [1:0] ST_MORE = 2'd0;
  localparam logic [1:0] ST_DONE = 2'd1;
  localparam logic [1:0] ST_ERR  = 2'd2;

  // Keyword bytes, index 0 first.
  localparam logic [8*3-1:0]  KW_GET  = "TEG";
  localparam logic [8*4-1:0]  KW_POST = "TSOP";
  localparam logic [8*4-1:0]  KW_HEAD = "DAEH";
  localparam logic [8*4-1:0]  KW_HOST = "tsoh";
  localparam logic [8*10-1:0] KW_CONN = "noitcennoc";
  localparam logic [8*10-1:0] KW_KA   = "evila-peek";
  localparam logic [8*14-1:0] KW_CLEN = "htgnel-tnetnoc";

  localparam logic [7:0] CASE_BIT = 8'h20;

  function automatic logic [7:0] lower_of(input logic [7:0] c);
    lower_of = (c >= "A" && c <= "Z") ? (c | CASE_BIT) : c;
  endfunction

  function automatic logic is_ctl(input logic [7:0] c);
    is_ctl = (c < 8'h20) || (c == 8'h7F);
  endfunction

  function automatic logic [4:0] digit_of(input logic [7:0] c);
    logic [7:0] l;
    l = lower_of(c);
    if (c >= "0" && c <= "9") digit_of = {1'b0, c[3:0]};
    else if (l >= "a" && l <= "f") digit_of = 5'(l - "a" + 8'd10);
    else digit_of = 5'd16;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/http_request_header_parser.sv */
// Top level of the HTTP request header parser.
//
// channel | direction | handshake        | payload
// in      | input     | in_valid/ready   | in_item_t  (data_byte, start_new)
// out     | output    | out_valid/ready  | out_item_t (status, flags, length)
//
// One byte per cycle: the parser state advances in the accept cycle and the
// result lands in the output register the same edge. A full output register
// that is being drained still accepts, so streaming holds one item per cycle while out_ready stays high.
// Reset (rst, synchronous) puts the parser at the first method byte.
// A stall on out holds the result and drops in_ready until it is taken.
`default_nettype none
module http_request_header_parser import hrhp_pkg::*; #(
  parameter int LENGTH_BITS = 32
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_item
);
  localparam logic [LENGTH_BITS-1:0] CAP = LENGTH_BITS'(1) << (LENGTH_BITS - 1);

  phase_t  phase, phase_next;
  pstate_t pst, pst_next;
  logic [3:0] tpos, tpos_next;
  logic [2:0] cand, cand_next;
  hkind_t  kind, kind_next;
  logic    ka_m, ka_m_next;
  logic [1:0] meth, meth_next;
  logic    ver, ver_next, kal, kal_next, hhost, hhost_next, hlen, hlen_next;
  logic [LENGTH_BITS-1:0] len, len_next;
  nstage_t nst, nst_q;
  nbase_t  nbs, nbs_q;
  logic    nng, nng_q;
  logic [LENGTH_BITS-1:0] nac, nac_q;
  logic    num_restart, num_feed;
  logic    uri;
  logic    take;

  assign in_ready = !out_valid || out_ready;
  assign take = in_valid && in_ready;

  hrhp_number #(.LENGTH_BITS(LENGTH_BITS)) u_num (
    .c(in_item.data_byte), .restart(num_restart),
    .stage(nst_q), .base(nbs_q), .neg(nng_q), .acc(nac_q),
    .stage_next(nst), .base_next(nbs), .neg_next(nng), .acc_next(nac)
  );

  always_comb begin
    logic [7:0] c, l;
    logic bad, up, alpha;
    phase_t ph; pstate_t ps; logic [3:0] tp; logic [2:0] cd; hkind_t kd;
    logic km; logic [1:0] me; logic vr, ka, hh, hl; logic [LENGTH_BITS-1:0] ln;
    c = in_item.data_byte;
    l = lower_of(c);
    up = c >= "A" && c <= "Z";
    alpha = up || (c >= "a" && c <= "z");
    bad = 1'b0;
    uri = 1'b0;
    num_restart = 1'b0;
    num_feed = 1'b0;
    if (in_item.start_new) begin
      ph = PH_LINE; ps = S_M0; tp = '0; cd = '0; kd = K_NONE; km = 1'b0;
      me = '0; vr = 1'b0; ka = 1'b0; hh = 1'b0; hl = 1'b0; ln = '0;
    end else begin
      ph = phase; ps = pst; tp = tpos; cd = cand; kd = kind; km = ka_m;
      me = meth; vr = ver; ka = kal; hh = hhost; hl = hlen; ln = len;
    end
    phase_next = ph; pst_next = ps; tpos_next = tp; cand_next = cd;
    kind_next = kd; ka_m_next = km; meth_next = me; ver_next = vr;
    kal_next = ka; hhost_next = hh; hlen_next = hl; len_next = ln;
    if (ph == PH_LINE || ph == PH_HEAD) begin
      case (ps)
        S_M0, S_METHOD: begin
          if (up) begin
            if (ps == S_M0) begin tp = '0; cd = 3'b111; end
            if (tp < 4'd3 && c != KW_GET[8*tp +: 8])  cd[0] = 1'b0;
            if (tp < 4'd4 && c != KW_POST[8*tp +: 8]) cd[1] = 1'b0;
            if (tp < 4'd4 && c != KW_HEAD[8*tp +: 8]) cd[2] = 1'b0;
            cand_next = cd;
            tpos_next = (tp < 4'd15) ? tp + 4'd1 : tp;
            pst_next = S_METHOD;
          end else if (c == " " && ps == S_METHOD) begin
            if (cd[0] && tp >= 4'd3) meth_next = 2'd0;
            else if (cd[1] && tp >= 4'd4) meth_next = 2'd1;
            else if (cd[2] && tp >= 4'd4) meth_next = 2'd2;
            else bad = 1'b1;
            pst_next = S_SP_URI;
          end else bad = 1'b1;
        end
        S_SP_URI: begin
          if (c == "/") begin uri = 1'b1; pst_next = S_URI; end
          else if (c != " ") bad = 1'b1;
        end
        S_URI: begin
          if (c == " ") pst_next = S_SP_VER;
          else if (!is_ctl(c)) uri = 1'b1;
          else bad = 1'b1;
        end
        S_SP_VER: begin
          if ((c | CASE_BIT) == "h") pst_next = S_H;
          else if (c != " ") bad = 1'b1;
        end
        S_H:    if ((c | CASE_BIT) == "t") pst_next = S_HT; else bad = 1'b1;
        S_HT:   if ((c | CASE_BIT) == "t") pst_next = S_HTT; else bad = 1'b1;
        S_HTT:  if ((c | CASE_BIT) == "p") pst_next = S_HTTP; else bad = 1'b1;
        S_HTTP: if (c == "/") pst_next = S_SL; else bad = 1'b1;
        S_SL:   if (c == "1") pst_next = S_ONE; else bad = 1'b1;
        S_ONE:  if (c == ".") pst_next = S_DOT; else bad = 1'b1;
        S_DOT: begin
          if (c == "0") begin ver_next = 1'b0; kal_next = 1'b0; pst_next = S_SP_END; end
          else if (c == "1") begin ver_next = 1'b1; kal_next = 1'b1; pst_next = S_SP_END; end
          else bad = 1'b1;
        end
        S_SP_END: begin
          if (c == 8'h0D) pst_next = S_LCR;
          else if (c != " ") bad = 1'b1;
        end
        S_LCR: begin
          if (c == 8'h0A) begin phase_next = PH_HEAD; pst_next = S_H0; end
          else bad = 1'b1;
        end
        S_H0, S_NAME: begin
          if (c == 8'h0D && ps == S_H0) pst_next = S_ECR;
          else if (alpha || c == "-") begin
            if (ps == S_H0) begin tp = '0; cd = 3'b111; end
            if (tp < 4'd4 && l != KW_HOST[8*tp +: 8]) cd[0] = 1'b0;
            if (tp < 4'd10 && l != KW_CONN[8*tp +: 8]) cd[1] = 1'b0;
            if (tp < 4'd14 && l != KW_CLEN[8*tp +: 8]) cd[2] = 1'b0;
            cand_next = cd;
            kind_next = K_NONE;
            ka_m_next = 1'b0;
            tpos_next = (tp < 4'd15) ? tp + 4'd1 : tp;
            pst_next = S_NAME;
          end else if (c == ":" && ps == S_NAME) begin
            if (cd[0] && tp >= 4'd4) kind_next = K_HOST;
            else if (cd[1] && tp >= 4'd10) kind_next = K_CONN;
            else if (cd[2] && tp >= 4'd14) kind_next = K_CLEN;
            else kind_next = K_NONE;
            cand_next = '0;
            ka_m_next = 1'b0;
            pst_next = S_SP_VAL;
          end else bad = 1'b1;
        end
        S_SP_VAL, S_VAL: begin
          if (ps == S_VAL && (c == 8'h0D || c == " ")) begin
            case (kd)
              K_HOST: hhost_next = 1'b1;
              K_CONN: kal_next = km && tp >= 4'd10;
              K_CLEN: begin
                hlen_next = 1'b1;
                if (nng_q) len_next = '0 - ((nac_q >= CAP) ? CAP : nac_q);
                else len_next = (nac_q >= CAP) ? CAP - 1'b1 : nac_q;
              end
              default: ;
            endcase
            pst_next = (c == 8'h0D) ? S_HCR : S_SP_VAL;
          end else if (ps == S_SP_VAL && c == " ") begin
          end else if (!is_ctl(c)) begin
            if (ps == S_SP_VAL) begin tp = '0; km = 1'b1; num_restart = 1'b1; end
            num_feed = 1'b1;
            if (tp < 4'd10 && l != KW_KA[8*tp +: 8]) km = 1'b0;
            ka_m_next = km;
            tpos_next = (tp < 4'd15) ? tp + 4'd1 : tp;
            pst_next = S_VAL;
          end else bad = 1'b1;
        end
        S_HCR: if (c == 8'h0A) pst_next = S_H0; else bad = 1'b1;
        S_ECR: if (c == 8'h0A) phase_next = PH_DONE; else bad = 1'b1;
        default: bad = 1'b1;
      endcase
      if (bad) begin
        phase_next = PH_ERR;
        uri = 1'b0;
      end
    end
  end

  // Advance parser state on each accepted item.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_LINE; pst <= S_M0; tpos <= '0; cand <= '0; kind <= K_NONE;
      ka_m <= 1'b0; meth <= '0; ver <= 1'b0; kal <= 1'b0; hhost <= 1'b0;
      hlen <= 1'b0; len <= '0; nst_q <= N_START; nbs_q <= B_DEC; nng_q <= 1'b0;
      nac_q <= '0; out_valid <= 1'b0;
    end else begin
      if (take) begin
        phase <= phase_next; pst <= pst_next; tpos <= tpos_next;
        cand <= cand_next; kind <= kind_next; ka_m <= ka_m_next;
        meth <= meth_next; ver <= ver_next; kal <= kal_next;
        hhost <= hhost_next; hlen <= hlen_next; len <= len_next;
        if (num_feed) begin
          nst_q <= nst; nbs_q <= nbs; nng_q <= nng; nac_q <= nac;
        end
        out_valid <= 1'b1;
      end else if (out_ready) out_valid <= 1'b0;
    end
  end

  // Result register; holds while the consumer stalls.
  always_ff @(posedge clk) begin
    if (take) begin
      case (phase_next)
        PH_DONE: out_item.status <= ST_DONE;
        PH_ERR:  out_item.status <= ST_ERR;
        default: out_item.status <= ST_MORE;
      endcase
      out_item.uri_byte <= uri;
      out_item.method_code <= meth_next;
      out_item.version_minor <= ver_next;
      out_item.persist <= kal_next;
      out_item.has_host <= hhost_next;
      out_item.has_length <= hlen_next;
      out_item.body_len <= 32'(signed'(len_next));
    end
  end
endmodule
`default_nettype wire

/* rtl/core/hrhp_number.sv */
// Content-Length number reader: sign, base prefix and saturating accumulate.
`default_nettype none
module hrhp_number import hrhp_pkg::*; #(
  parameter int LENGTH_BITS = 32
) (
  input  wire logic [7:0]       c,
  input  wire logic             restart,
  input  wire nstage_t          stage,
  input  wire nbase_t           base,
  input  wire logic             neg,
  input  wire logic [LENGTH_BITS-1:0] acc,
  output nstage_t               stage_next,
  output nbase_t                base_next,
  output logic                  neg_next,
  output logic [LENGTH_BITS-1:0] acc_next
);
  localparam logic [LENGTH_BITS-1:0] CAP = LENGTH_BITS'(1) << (LENGTH_BITS - 1);

  logic [4:0] d;
  nstage_t st;
  nbase_t bs;
  logic ng;
  logic [LENGTH_BITS-1:0] ac;
  logic [4:0] radix;
  logic [LENGTH_BITS+4:0] prod;

  always_comb begin
    d = digit_of(c);
    st = restart ? N_START : stage;
    bs = restart ? B_DEC : base;
    ng = restart ? 1'b0 : neg;
    ac = restart ? '0 : acc;
    // Scale the accumulator by the radix with shifts, plus one add for decimal.
    case (bs)
      B_OCT: begin
        radix = 5'd8;
        prod = {2'd0, ac, 3'd0};
      end
      B_HEX: begin
        radix = 5'd16;
        prod = {1'd0, ac, 4'd0};
      end
      default: begin
        radix = 5'd10;
        prod = {2'd0, ac, 3'd0} + {4'd0, ac, 1'd0};
      end
    endcase
    stage_next = st;
    base_next = bs;
    neg_next = ng;
    acc_next = ac;
    case (st)
      N_START, N_SIGN: begin
        if (st == N_START && (c == "+" || c == "-")) begin
          if (c == "-") neg_next = 1'b1;
          stage_next = N_SIGN;
        end else if (c == "0") begin
          stage_next = N_ZERO;
        end else if (d >= 5'd1 && d <= 5'd9) begin
          acc_next = LENGTH_BITS'(d);
          stage_next = N_DIG;
        end else stage_next = N_STOP;
      end
      N_ZERO: begin
        if (c == "x" || c == "X") stage_next = N_X;
        else if (d < 5'd8) begin
          base_next = B_OCT;
          acc_next = LENGTH_BITS'(d);
          stage_next = N_DIG;
        end else stage_next = N_STOP;
      end
      N_X: begin
        if (d < 5'd16) begin
          base_next = B_HEX;
          acc_next = LENGTH_BITS'(d);
          stage_next = N_DIG;
        end else stage_next = N_STOP;
      end
      N_DIG: begin
        if (d < radix) begin
          // Saturate once acc*radix + d would pass CAP.
          if (prod + (LENGTH_BITS+5)'(d) > {5'd0, CAP}) acc_next = CAP;
          else acc_next = prod[LENGTH_BITS-1:0] + LENGTH_BITS'(d);
        end else stage_next = N_STOP;
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

/* bench/parser_checker.sv */
// Checker: predicts parser results from accepted bytes and compares them.
`timescale 1ns / 1ps
module parser_checker import hrhp_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  input  wire logic      in_ready,
  input  wire in_item_t  in_item,
  input  wire logic      out_valid,
  input  wire logic      out_ready,
  input  wire out_item_t out_item,
  output int             errors,
  output int             pending
);
  localparam longint unsigned CAP = 64'd1 << 31;

  phase_t          ph;
  pstate_t         ps;
  logic [3:0]      pos;
  logic [2:0]      cand;
  hkind_t          kind;
  logic            ka_ok;
  longint unsigned acc;
  nbase_t          base;
  logic            neg;
  nstage_t         stg;
  logic [1:0]      meth;
  logic            ver, kal, host, hlen;
  logic [31:0]     clen;
  out_item_t       results_due[$];

  function automatic logic [7:0] lc(logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'h20 : c;
  endfunction
  function automatic logic ctl(logic [7:0] c);
    return c < 8'h20 || c == 8'h7F;
  endfunction
  function automatic logic alpha(logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction
  function automatic int dig(logic [7:0] c);
    logic [7:0] l;
    l = lc(c);
    if (c >= "0" && c <= "9") return c - "0";
    if (l >= "a" && l <= "f") return l - "a" + 10;
    return 16;
  endfunction
  function automatic logic kw_hit(string kw, logic [7:0] c, logic ci);
    if (pos >= kw.len()) return 1'b1;
    return ci ? lc(c) == lc(kw[pos]) : c == kw[pos];
  endfunction

  function automatic void clear_parser();
    ph = PH_LINE; ps = S_M0; pos = 0; cand = 0; kind = K_NONE; ka_ok = 0;
    acc = 0; base = B_DEC; neg = 0; stg = N_START;
    meth = 0; ver = 0; kal = 0; host = 0; hlen = 0; clen = 0;
  endfunction

  function automatic void bump();
    if (pos < 15) pos++;
  endfunction

  function automatic void feed_number(logic [7:0] c);
    int d, b;
    d = dig(c);
    b = base == B_OCT ? 8 : base == B_HEX ? 16 : 10;
    case (stg)
      N_START, N_SIGN: begin
        if (stg == N_START && (c == "+" || c == "-")) begin
          if (c == "-") neg = 1;
          stg = N_SIGN;
        end else if (c == "0") stg = N_ZERO;
        else if (d >= 1 && d <= 9) begin
          acc = d; stg = N_DIG;
        end else stg = N_STOP;
      end
      N_ZERO: begin
        if (c == "x" || c == "X") stg = N_X;
        else if (d < 8) begin
          base = B_OCT; acc = d; stg = N_DIG;
        end else stg = N_STOP;
      end
      N_X: begin
        if (d < 16) begin
          base = B_HEX; acc = d; stg = N_DIG;
        end else stg = N_STOP;
      end
      N_DIG: begin
        if (d < b) begin
          if (acc > (CAP - d) / b) acc = CAP;
          else acc = acc * b + d;
        end else stg = N_STOP;
      end
      default: ;
    endcase
  endfunction

  function automatic void value_byte(logic [7:0] c);
    if (!kw_hit("keep-alive", c, 1)) ka_ok = 0;
    feed_number(c);
    bump();
  endfunction

  function automatic void end_token();
    case (kind)
      K_HOST: host = 1;
      K_CONN: kal = ka_ok && pos >= 10;
      K_CLEN: begin
        hlen = 1;
        if (neg) clen = 32'(64'd0 - (acc >= CAP ? CAP : acc));
        else clen = 32'(acc >= CAP ? CAP - 1 : acc);
      end
      default: ;
    endcase
  endfunction

  function automatic void method_byte(logic [7:0] c);
    if (!kw_hit("GET", c, 0)) cand[0] = 0;
    if (!kw_hit("POST", c, 0)) cand[1] = 0;
    if (!kw_hit("HEAD", c, 0)) cand[2] = 0;
    bump();
  endfunction

  function automatic void name_byte(logic [7:0] c);
    if (!kw_hit("Host", c, 1)) cand[0] = 0;
    if (!kw_hit("Connection", c, 1)) cand[1] = 0;
    if (!kw_hit("Content-Length", c, 1)) cand[2] = 0;
    bump();
  endfunction

  // Advance the parser one byte; return whether the byte is in the URI.
  function automatic logic parse_byte(logic [7:0] c);
    logic uri, bad;
    uri = 0; bad = 0;
    case (ps)
      S_M0: if (c >= "A" && c <= "Z") begin
        pos = 0; cand = 3'b111; method_byte(c); ps = S_METHOD;
      end else bad = 1;
      S_METHOD: if (c >= "A" && c <= "Z") method_byte(c);
      else if (c == " ") begin
        if (cand[0] && pos >= 3) meth = 0;
        else if (cand[1] && pos >= 4) meth = 1;
        else if (cand[2] && pos >= 4) meth = 2;
        else bad = 1;
        ps = S_SP_URI;
      end else bad = 1;
      S_SP_URI: if (c == "/") begin
        uri = 1; ps = S_URI;
      end else if (c != " ") bad = 1;
      S_URI: if (c == " ") ps = S_SP_VER;
      else if (!ctl(c)) uri = 1;
      else bad = 1;
      S_SP_VER: if ((c | 8'h20) == "h") ps = S_H;
      else if (c != " ") bad = 1;
      S_H: if ((c | 8'h20) == "t") ps = S_HT; else bad = 1;
      S_HT: if ((c | 8'h20) == "t") ps = S_HTT; else bad = 1;
      S_HTT: if ((c | 8'h20) == "p") ps = S_HTTP; else bad = 1;
      S_HTTP: if (c == "/") ps = S_SL; else bad = 1;
      S_SL: if (c == "1") ps = S_ONE; else bad = 1;
      S_ONE: if (c == ".") ps = S_DOT; else bad = 1;
      S_DOT: if (c == "0") begin
        ver = 0; kal = 0; ps = S_SP_END;
      end else if (c == "1") begin
        ver = 1; kal = 1; ps = S_SP_END;
      end else bad = 1;
      S_SP_END: if (c == 8'h0D) ps = S_LCR; else if (c != " ") bad = 1;
      S_LCR: if (c == 8'h0A) begin
        ph = PH_HEAD; ps = S_H0;
      end else bad = 1;
      S_H0: if (c == 8'h0D) ps = S_ECR;
      else if (alpha(c) || c == "-") begin
        pos = 0; cand = 3'b111; kind = K_NONE; ka_ok = 0;
        name_byte(c); ps = S_NAME;
      end else bad = 1;
      S_NAME: if (alpha(c) || c == "-") name_byte(c);
      else if (c == ":") begin
        kind = (cand[0] && pos >= 4) ? K_HOST : (cand[1] && pos >= 10) ? K_CONN :
               (cand[2] && pos >= 14) ? K_CLEN : K_NONE;
        cand = 0; ka_ok = 0; ps = S_SP_VAL;
      end else bad = 1;
      S_SP_VAL: if (c != " ") begin
        if (!ctl(c)) begin
          pos = 0; ka_ok = 1; acc = 0; base = B_DEC; neg = 0; stg = N_START;
          value_byte(c); ps = S_VAL;
        end else bad = 1;
      end
      S_VAL: if (c == 8'h0D || c == " ") begin
        end_token(); ps = c == 8'h0D ? S_HCR : S_SP_VAL;
      end else if (!ctl(c)) value_byte(c);
      else bad = 1;
      S_HCR: if (c == 8'h0A) ps = S_H0; else bad = 1;
      S_ECR: if (c == 8'h0A) ph = PH_DONE; else bad = 1;
      default: bad = 1;
    endcase
    if (bad) ph = PH_ERR;
    return uri && !bad;
  endfunction

  function automatic out_item_t predict(in_item_t it);
    out_item_t r;
    logic u;
    u = 0;
    if (it.start_new) clear_parser();
    if (ph == PH_LINE || ph == PH_HEAD) u = parse_byte(it.data_byte);
    r.status = ph == PH_DONE ? ST_DONE : ph == PH_ERR ? ST_ERR : ST_MORE;
    r.uri_byte = u; r.method_code = meth; r.version_minor = ver;
    r.persist = kal; r.has_host = host; r.has_length = hlen;
    r.body_len = clen;
    return r;
  endfunction

  task automatic cmp(string name, longint e, longint a);
    if (e != a) begin
      $error("%s mismatch: expected %0d, got %0d", name, e, a);
      errors++;
    end
  endtask

  initial begin
    errors = 0;
    clear_parser();
  end

  assign pending = results_due.size();

  always @(posedge clk) begin
    out_item_t e;
    if (!rst) begin
      if (in_valid && in_ready) results_due.push_back(predict(in_item));
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          $error("result with no expectation waiting");
          errors++;
        end else begin
          e = results_due.pop_front();
          cmp("status", e.status, out_item.status);
          cmp("uri_byte", e.uri_byte, out_item.uri_byte);
          cmp("method_code", e.method_code, out_item.method_code);
          cmp("version_minor", e.version_minor, out_item.version_minor);
          cmp("persist", e.persist, out_item.persist);
          cmp("has_host", e.has_host, out_item.has_host);
          cmp("has_length", e.has_length, out_item.has_length);
          cmp("body_len", e.body_len, out_item.body_len);
        end
      end
    end
  end
endmodule

/* bench/testbench.sv */
// Top of the parser bench: clock, reset, byte stimulus and the verdict.
`timescale 1ns / 1ps
module testbench;
  import hrhp_pkg::*;

  logic      clk, rst;
  logic      in_valid, in_ready, out_valid, out_ready;
  in_item_t  in_item;
  out_item_t out_item;
  int        errors, pending;
  int        cycles;
  int        hold_off;     // receiver hold-off left, in cycles
  logic      want_hold;
  logic      pace;         // sender may skip cycles
  byte unsigned msg[$];    // bytes of the next request to send
  bit          first_of[$];

  http_request_header_parser uut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .in_item(in_item), .out_valid(out_valid), .out_ready(out_ready),
    .out_item(out_item)
  );

  parser_checker chk (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .in_item(in_item), .out_valid(out_valid), .out_ready(out_ready),
    .out_item(out_item), .errors(errors), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // Watchdog: end the run far beyond the slowest correct run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver: stall on its own pattern; a long hold-off when asked.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 0;
      hold_off <= 0;
    end else if (want_hold && hold_off == 0) begin
      hold_off <= 300;
      out_ready <= 0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= hold_off == 1;
    end else begin
      case (cycles[6:5])
        2'd0: out_ready <= 1;
        2'd1: out_ready <= ($urandom_range(0, 3) != 0);
        2'd2: out_ready <= ($urandom_range(0, 1) != 0);
        default: out_ready <= ($urandom_range(0, 9) == 0) ? 0 : 1;
      endcase
    end
  end

  function automatic string pick(string a[]);
    return a[$urandom_range(0, a.size() - 1)];
  endfunction

  function automatic string rand_case(string s);
    string r;
    r = s;
    for (int i = 0; i < s.len(); i++)
      if ($urandom_range(0, 1)) r[i] = (s[i] >= "a" && s[i] <= "z") ? s[i] - 8'h20 :
                                       (s[i] >= "A" && s[i] <= "Z") ? s[i] + 8'h20 : s[i];
    return r;
  endfunction

  function automatic string spaces(int lo, int hi);
    string s;
    s = "";
    repeat ($urandom_range(lo, hi)) s = {s, " "};
    return s;
  endfunction

  function automatic string number_text();
    string s;
    s = pick('{"", "", "+", "-"});
    case ($urandom_range(0, 6))
      0: s = {s, $sformatf("%0d", $urandom())};
      1: s = {s, $sformatf("0x%0h", {$urandom(), $urandom()})};
      2: s = {s, $sformatf("0%0o", $urandom())};
      3: s = {s, pick('{"0x", "0xg", "0", "2147483647", "2147483648", "99999999999",
                         "0X7fffffff", "09", "abc", "12z"})};
      default: s = {s, $sformatf("%0d", $urandom_range(0, 5000))};
    endcase
    return s;
  endfunction

  function automatic string header_line();
    string n, v;
    case ($urandom_range(0, 5))
      0: n = rand_case(pick('{"Host", "Hostname", "Hos"}));
      1: n = rand_case(pick('{"Connection", "Connectionx", "Conn"}));
      2: n = rand_case(pick('{"Content-Length", "Content-Lengths", "Content"}));
      3: n = pick('{"Accept", "User-Agent", "X-Foo", "-"});
      default: n = rand_case(pick('{"Host", "Connection", "Content-Length"}));
    endcase
    v = "";
    repeat ($urandom_range(1, 3)) begin
      if (v.len() > 0) v = {v, spaces(1, 2)};
      case ($urandom_range(0, 3))
        0: v = {v, rand_case(pick('{"keep-alive", "close", "keep-alives", "keep"}))};
        1: v = {v, pick('{"example.org", "a", "\x80\xff~"})};
        default: v = {v, number_text()};
      endcase
    end
    return {n, ":", spaces(0, 2), v, "\r\n"};
  endfunction

  // Build one request; the method is often malformed, sometimes broken at one byte.
  task automatic build_request();
    string s;
    int k;
    s = {pick('{"GET", "POST", "HEAD", "GETX", "POSTED", "HEADER", "PUT", "GE"}),
         spaces(1, 2), "/", pick('{"", "index.html", "a?b=c", "\x80\xfe"}),
         spaces(1, 2), rand_case("http"), "/1.", pick('{"0", "1"}), spaces(0, 1),
         "\r\n"};
    repeat ($urandom_range(0, 4)) s = {s, header_line()};
    s = {s, "\r\n"};
    if ($urandom_range(0, 4) == 0) begin
      k = $urandom_range(0, s.len() - 1);
      s[k] = $urandom_range(0, 255);
    end
    for (int i = 0; i < s.len(); i++) begin
      msg.push_back(s[i]);
      first_of.push_back(i == 0);
    end
    // Trailing bytes after the end are ignored by the block.
    repeat ($urandom_range(0, 2)) begin
      msg.push_back($urandom_range(0, 255));
      first_of.push_back(0);
    end
  endtask

  task automatic queue_text(string s, bit fresh);
    for (int i = 0; i < s.len(); i++) begin
      msg.push_back(s[i]);
      first_of.push_back(fresh && i == 0);
    end
  endtask

  // Offer one byte and hold it until it is accepted.
  task automatic send_byte(byte unsigned b, bit fresh);
    in_valid <= 1;
    in_item <= '{data_byte: b, start_new: fresh};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain_queue();
    int burst;
    burst = 0;
    while (msg.size() > 0) begin
      if (pace && burst == 0) begin
        in_valid <= 0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
        burst = $urandom_range(1, 20);
      end
      send_byte(msg.pop_front(), first_of.pop_front());
      if (burst > 0) burst--;
    end
  endtask

  initial begin
    int sent;
    rst = 1; in_valid = 0; in_item = '0; want_hold = 0; pace = 0; cycles = 0;
    repeat (3) @(posedge clk);
    rst <= 0;
    // Directed requests: GET and POST, both versions, each header and several error cases.
    queue_text("GET / HTTP/1.1\r\nHost: x\r\nConnection: close\r\n\r\n", 1);
    queue_text("POST /a hTtP/1.0  \r\ncontent-length: -0x7FFFFFFF1\r\n\r\nzz", 1);
    queue_text("HEADX / HTTP/1.0\r\nConnection: Keep-Alive\r\n\r\n", 1);
    queue_text("get / HTTP/1.1\r\n", 1);
    queue_text("GET / HTTP/2.0\r\n", 1);
    queue_text("GET / HTTP/1.1\rX", 1);
    queue_text("GET / HTTP/1.1\r\nA: b \r\n", 1);
    queue_text("PUT / HTTP/1.1\r\n", 1);
    queue_text("\x00\xff", 1);
    drain_queue();
    // One long receiver hold-off while the sender keeps offering bytes.
    want_hold <= 1;
    @(posedge clk);
    want_hold <= 0;
    build_request();
    build_request();
    drain_queue();
    in_valid <= 0;
    // Sender pause until every expected result has come.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    pace = 1;
    sent = 0;
    while (sent < 1600) begin
      if ($urandom_range(0, 9) == 0) begin
        msg.push_back($urandom_range(0, 255));
        first_of.push_back($urandom_range(0, 1));
      end else build_request();
      sent += msg.size();
      pace = $urandom_range(0, 3) != 0;
      drain_queue();
    end
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule
